[hw/rtl/fbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fbr_pkg;

  localparam logic [7:0] HEADER_RESET = 8'h7E;

  // Two mailbox slots plus one free buffer for the frame being assembled
  localparam int NUM_SLOTS = 2;
  localparam int NUM_BUFS  = 3;
  localparam int BUF_W     = 2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } parse_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_SHOW  = 2'd2,
    ST_EMPTY = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic byte_take;    // parse the accepted serial byte
    logic fetch_start;  // pick the slot to deliver, clear the index
    logic read_issue;   // read the current stored byte
    logic out_advance;  // step to the next stored byte
    logic out_done;     // empty the delivered slot
    logic show;         // a stored byte is on the output
    logic empty;        // the no-message result is on the output
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_msg;   // at least one slot holds a message
    logic out_last;  // current byte is the final one of the slot
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/fbr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module fbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fbr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module fbr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_fetch,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire fbr_pkg::dp_status_t status,
  output fbr_pkg::ctrl_cmd_t       cmd
);

  fbr_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fbr_pkg::ST_IDLE: begin
        if (in_valid && in_fetch) begin
          state_next = status.has_msg ? fbr_pkg::ST_READ : fbr_pkg::ST_EMPTY;
        end
      end
      fbr_pkg::ST_READ: begin
        state_next = fbr_pkg::ST_SHOW;
      end
      fbr_pkg::ST_SHOW: begin
        if (out_ready) begin
          state_next = status.out_last ? fbr_pkg::ST_IDLE : fbr_pkg::ST_READ;
        end
      end
      fbr_pkg::ST_EMPTY: begin
        if (out_ready) begin
          state_next = fbr_pkg::ST_IDLE;
        end
      end
      default: state_next = fbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      fbr_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.byte_take   = in_valid && !in_fetch;
        cmd.fetch_start = in_valid && in_fetch;
      end
      fbr_pkg::ST_READ: begin
        cmd.read_issue = 1'b1;
      end
      fbr_pkg::ST_SHOW: begin
        out_valid       = 1'b1;
        cmd.show        = 1'b1;
        cmd.out_advance = out_ready && !status.out_last;
        cmd.out_done    = out_ready && status.out_last;
      end
      fbr_pkg::ST_EMPTY: begin
        out_valid = 1'b1;
        cmd.empty = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/fbr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module fbr_datapath #(
  parameter int MAX_PAYLOAD = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic [7:0]          in_byte,
  input  wire fbr_pkg::ctrl_cmd_t  cmd,
  output fbr_pkg::dp_status_t      status,
  output logic                     out_flag,
  output logic [7:0]               out_byte,
  output logic                     out_last
);

  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int DEPTH  = fbr_pkg::NUM_BUFS * MAX_PAYLOAD;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]                  header_byte;
  fbr_pkg::parse_phase_t       phase;
  logic [LEN_W-1:0]            frame_length;
  logic [LEN_W-1:0]            byte_count;
  logic [7:0]                  running_xor;
  logic [fbr_pkg::BUF_W-1:0]   asm_buf;
  logic [fbr_pkg::BUF_W-1:0]   free_buf;
  logic [LEN_W-1:0]            slot_size [fbr_pkg::NUM_SLOTS];
  logic [fbr_pkg::BUF_W-1:0]   slot_buf  [fbr_pkg::NUM_SLOTS];
  logic                        cur_slot;
  logic [LEN_W-1:0]            out_idx;
  logic [LEN_W-1:0]            count_inc;
  logic                        len_bad;
  logic                        ram_we;
  logic [ADDR_W-1:0]           waddr;
  logic [ADDR_W-1:0]           raddr;
  logic [7:0]                  rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= fbr_pkg::HEADER_RESET;
    end else if (cfg_we) begin
      header_byte <= cfg_wdata;
    end
  end

  // Lowest buffer not held by a full slot
  always_comb begin
    free_buf = '0;
    for (int k = fbr_pkg::NUM_BUFS - 1; k >= 0; k--) begin
      if (!((slot_size[0] != '0) && (slot_buf[0] == fbr_pkg::BUF_W'(k))) &&
          !((slot_size[1] != '0) && (slot_buf[1] == fbr_pkg::BUF_W'(k)))) begin
        free_buf = fbr_pkg::BUF_W'(k);
      end
    end
  end

  assign count_inc = byte_count + LEN_W'(1);
  assign len_bad   = (in_byte == 8'd0) || (in_byte > 8'(MAX_PAYLOAD));
  assign ram_we    = cmd.byte_take && (phase == fbr_pkg::PH_DATA);
  assign waddr     = ADDR_W'(asm_buf) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(byte_count);
  assign raddr     = ADDR_W'(slot_buf[cur_slot]) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(out_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= fbr_pkg::PH_HUNT;
      byte_count <= '0;
      slot_size  <= '{default: '0};
    end else begin
      if (cmd.byte_take) begin
        unique case (phase)
          fbr_pkg::PH_HUNT: begin
            if (in_byte == header_byte) begin
              phase      <= fbr_pkg::PH_LEN;
              byte_count <= '0;
            end
          end
          fbr_pkg::PH_LEN: begin
            if (len_bad) begin
              phase <= fbr_pkg::PH_HUNT;
            end else begin
              frame_length <= LEN_W'(in_byte);
              running_xor  <= in_byte;
              byte_count   <= '0;
              asm_buf      <= free_buf;
              phase        <= fbr_pkg::PH_DATA;
            end
          end
          fbr_pkg::PH_DATA: begin
            running_xor <= running_xor ^ in_byte;
            byte_count  <= count_inc;
            if (count_inc >= frame_length) begin
              phase <= fbr_pkg::PH_SUM;
            end
          end
          fbr_pkg::PH_SUM: begin
            phase <= fbr_pkg::PH_HUNT;
            // Commit without copying: the slot takes over the assembly buffer
            if (running_xor == in_byte) begin
              if (slot_size[0] == '0) begin
                slot_size[0] <= frame_length;
                slot_buf[0]  <= asm_buf;
              end else if (slot_size[1] == '0) begin
                slot_size[1] <= frame_length;
                slot_buf[1]  <= asm_buf;
              end
            end
          end
          default: phase <= fbr_pkg::PH_HUNT;
        endcase
      end
      if (cmd.out_done) begin
        slot_size[cur_slot] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_start) begin
      cur_slot <= (slot_size[0] == '0);
      out_idx  <= '0;
    end else if (cmd.out_advance) begin
      out_idx <= out_idx + LEN_W'(1);
    end
  end

  fbr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_byte),
    .re    (cmd.read_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign status.has_msg  = (slot_size[0] != '0) || (slot_size[1] != '0);
  assign status.out_last = ((out_idx + LEN_W'(1)) == slot_size[cur_slot]);

  assign out_flag = cmd.show;
  assign out_byte = cmd.show ? rdata : 8'd0;
  assign out_last = cmd.show ? status.out_last : cmd.empty;

endmodule
`default_nettype wire

[hw/rtl/framed_byte_receiver_two_slot_unit.sv]
// Sequence: a serial byte is parsed in the cycle it is accepted; a fetch shows its first stored
//   byte after the READ state and the registered RAM read, an empty result from the EMPTY state.
// Rate: one serial byte per cycle while idle; the input is stalled while a fetch result is
//   offered. Each stored byte takes a read-then-show step through the single RAM read port.
// Reset: rst is synchronous, active high; clears the parser to header hunting,
//   empties both slots and loads the header byte with 0x7E.
`timescale 1ns / 1ps
`default_nettype none
module framed_byte_receiver_two_slot_unit #(
  parameter int MAX_PAYLOAD = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Header byte register write
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] command (1 = fetch)
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] message_byte
  output logic [0:0]       m_tuser,   // [0] received_flag
  output logic             m_tlast    // last result of a fetch
);

  fbr_pkg::ctrl_cmd_t  cmd;
  fbr_pkg::dp_status_t status;
  logic                out_flag;
  logic [7:0]          out_byte;
  logic                out_last;

  // Controller: sequences one transfer at a time; a fetch walks the slot byte by byte
  fbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_fetch  (s_tuser[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: frame parser, slot bookkeeping and the shared payload RAM.
  // Three buffers rotate between the two slots and the frame being assembled,
  // so a commit only hands over a buffer index instead of copying bytes.
  fbr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_flag  (out_flag),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // Drive the result fields onto the output stream
  assign m_tdata    = out_byte;
  assign m_tuser[0] = out_flag;
  assign m_tlast    = out_last;

endmodule
`default_nettype wire

[hw/rtl/fbr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module fbr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  // One item at a time: no input taken while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // A serial byte never blocks the next transfer
  a_byte_single_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
    else $error("serial byte stalled the input");

  // Non-final results always carry a delivered message byte
  a_flag_before_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0])
    else $error("non-last result without received flag");

  // Empty-fetch result is a single zero item
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'd0))
    else $error("empty fetch result malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=>
      m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled output changed");

endmodule

bind framed_byte_receiver_two_slot_unit fbr_checker u_fbr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

[sim/framed_byte_receiver_two_slot_unit_test.sv]
`timescale 1ns / 1ps
module framed_byte_receiver_two_slot_unit_test;

  localparam int MAX_PAYLOAD     = 16;
  localparam int IDLE_LIMIT      = 4000;  // cycles with no transfer on either side
  localparam int ITEMS_PER_PHASE = 80;
  localparam int LONG_HOLD       = 400;   // receiver back-pressure stretch

  // s_tuser command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic       flag;
    logic [7:0] data;
    logic       last;
  } delivery_t;

  // Tracks the parser, both slots and the header register; queues the bytes
  // that each fetch must deliver.
  class frame_mailbox_model;
    logic [7:0]            header;
    fbr_pkg::parse_phase_t phase;
    logic [4:0]            frame_len;
    logic [4:0]            byte_cnt;
    logic [7:0]            run_xor;
    logic [7:0]            asm_buf [MAX_PAYLOAD];
    logic [7:0]            slot_data [fbr_pkg::NUM_SLOTS][MAX_PAYLOAD];
    logic [4:0]            slot_len [fbr_pkg::NUM_SLOTS];
    delivery_t             delivery_q [$];
    int                    errors;
    int                    n_checked;

    function new();
      header    = fbr_pkg::HEADER_RESET;
      phase     = fbr_pkg::PH_HUNT;
      frame_len = '0;
      byte_cnt  = '0;
      run_xor   = '0;
      errors    = 0;
      n_checked = 0;
      for (int s = 0; s < fbr_pkg::NUM_SLOTS; s++) slot_len[s] = '0;
    endfunction

    function void note_transfer(logic cmd, logic [7:0] b);
      logic      found;
      delivery_t d;
      found = 1'b0;
      if (cmd == CMD_BYTE) begin
        case (phase)
          fbr_pkg::PH_HUNT: begin
            if (b == header) begin
              phase    = fbr_pkg::PH_LEN;
              byte_cnt = '0;
            end
          end
          fbr_pkg::PH_LEN: begin
            if (b == 8'd0 || b > MAX_PAYLOAD) begin
              phase = fbr_pkg::PH_HUNT;
            end else begin
              frame_len = b[4:0];
              run_xor   = b;
              byte_cnt  = '0;
              phase     = fbr_pkg::PH_DATA;
            end
          end
          fbr_pkg::PH_DATA: begin
            asm_buf[byte_cnt[3:0]] = b;
            run_xor                = run_xor ^ b;
            byte_cnt               = byte_cnt + 5'd1;
            if (byte_cnt >= frame_len) phase = fbr_pkg::PH_SUM;
          end
          default: begin
            phase = fbr_pkg::PH_HUNT;
            if (run_xor == b) begin
              for (int s = 0; s < fbr_pkg::NUM_SLOTS; s++) begin
                if (!found && slot_len[s] == 0) begin
                  for (int i = 0; i < frame_len; i++) slot_data[s][i] = asm_buf[i];
                  slot_len[s] = frame_len;
                  found       = 1'b1;
                end
              end
            end
          end
        endcase
      end else begin
        for (int s = 0; s < fbr_pkg::NUM_SLOTS; s++) begin
          if (!found && slot_len[s] != 0) begin
            for (int i = 0; i < slot_len[s]; i++) begin
              d.flag = 1'b1;
              d.data = slot_data[s][i];
              d.last = (i == slot_len[s] - 1);
              delivery_q.push_back(d);
            end
            slot_len[s] = '0;
            found       = 1'b1;
          end
        end
        if (!found) begin
          d.flag = 1'b0;
          d.data = 8'h00;
          d.last = 1'b1;
          delivery_q.push_back(d);
        end
      end
    endfunction

    function void check_delivery(logic flag, logic [7:0] tdata, logic tlast);
      delivery_t want;
      n_checked++;
      if (delivery_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: flag %0b byte %02h last %0b",
                 $time, flag, tdata, tlast);
        return;
      end
      want = delivery_q.pop_front();
      if (flag !== want.flag) begin
        errors++;
        $display("%0t: received_flag expected %0b actual %0b", $time, want.flag, flag);
      end
      if (tdata !== want.data) begin
        errors++;
        $display("%0t: message_byte expected %02h actual %02h", $time, want.data, tdata);
      end
      if (tlast !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, tlast);
      end
    endfunction

    function int pending();
      return delivery_q.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;  // [7:0] data_byte
  logic [0:0]  s_tuser   = 1'b0;   // [0] command
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;            // [7:0] message_byte
  logic [0:0]  m_tuser;            // [0] received_flag
  logic        m_tlast;

  frame_mailbox_model sb;
  int n_sent     = 0;
  int burst_left = 0;
  bit feeding    = 1'b0;  // high while the random stimulus is streaming

  framed_byte_receiver_two_slot_unit #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Offer one item and hold it until the transfer; then either keep the
  // burst going or drop valid for a random gap and pick the next burst length.
  task automatic send(input logic cmd, input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_transfer(cmd, b);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
    end
  endtask

  // Header, length, keep payload bytes; the checksum only goes out for a
  // complete frame, XORed with spoil to corrupt it on purpose.
  task automatic send_frame(input int len, input logic [7:0] spoil, input int keep);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] junk;
    sum = len[7:0];
    send(CMD_BYTE, sb.header);
    send(CMD_BYTE, len[7:0]);
    for (int i = 0; i < keep; i++) begin
      b    = 8'($urandom_range(0, 255));
      junk = 8'($urandom_range(0, 255));
      // occasionally fetch in the middle of the frame
      if ($urandom_range(0, 9) == 0) send(CMD_FETCH, junk);
      send(CMD_BYTE, b);
      sum = sum ^ b;
    end
    if (keep == len) send(CMD_BYTE, sum ^ spoil);
  endtask

  // Mostly well-formed frames with random content, plus fetches, bad
  // lengths, bad checksums, cut-off frames and line noise.
  task automatic run_random(input int count);
    int         pick;
    int         len;
    int         stop_at;
    logic [7:0] b;
    stop_at = n_sent + count;
    feeding = 1'b1;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) len = MAX_PAYLOAD;
      else if ($urandom_range(0, 1) == 0) len = $urandom_range(1, 3);
      else len = $urandom_range(1, MAX_PAYLOAD);
      b = 8'($urandom_range(0, 255));
      if (pick < 50) begin
        send_frame(len, 8'h00, len);
      end else if (pick < 58) begin
        send_frame(len, 8'($urandom_range(1, 255)), len);
      end else if (pick < 78) begin
        send(CMD_FETCH, b);
      end else if (pick < 86) begin
        send(CMD_BYTE, sb.header);
        if ($urandom_range(0, 1) == 0) send(CMD_BYTE, 8'h00);
        else send(CMD_BYTE, 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end else if (pick < 92) begin
        send_frame(len, 8'h00, $urandom_range(0, len - 1));
      end else begin
        repeat ($urandom_range(1, 4)) send(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hold the sender until every fetch has been delivered, then let the
  // parser settle before touching the register.
  task automatic drain();
    s_tvalid <= 1'b0;
    feeding = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.header = value;
  endtask

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_delivery(m_tuser[0], m_tdata, m_tlast);
  end

  // Receiver: stretches of always-ready, random, mostly-stalled and
  // mostly-ready patterns; once, a long hold while the sender keeps feeding
  // so the block backs up and stalls its input.
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && feeding && sb.n_checked >= 10) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: give up when nothing moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (!rst);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[framed_byte_receiver_two_slot_unit] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, header at its reset value.
    // Good one-byte frame lands in slot 0.
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h01); send(CMD_BYTE, 8'hFF); send(CMD_BYTE, 8'hFE);
    // Zero length, then a length byte equal to the header: both go back to
    // hunting, and the second is not taken as a new header.
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h00);
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h7E);
    // Fetch in the middle of a frame: slot 0 goes out, parsing carries on.
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h02); send(CMD_BYTE, 8'hAA);
    send(CMD_FETCH, 8'hFF);
    send(CMD_BYTE, 8'h55); send(CMD_BYTE, 8'hFD);
    // Bad checksum: drop the frame.
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h01); send(CMD_BYTE, 8'h80); send(CMD_BYTE, 8'h00);
    // Good frame into slot 1, then a good frame with both slots full.
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h01); send(CMD_BYTE, 8'h00); send(CMD_BYTE, 8'h01);
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h01); send(CMD_BYTE, 8'h01); send(CMD_BYTE, 8'h00);
    // Length just above the buffer size.
    send(CMD_BYTE, 8'h7E); send(CMD_BYTE, 8'h11);
    // Slot 0, slot 1, then the empty-mailbox result.
    send(CMD_FETCH, 8'h00); send(CMD_FETCH, 8'h00); send(CMD_FETCH, 8'h00);
    drain();

    // Random phases over several header settings, extremes included.
    write_header(8'h00);
    run_random(ITEMS_PER_PHASE);
    drain();
    write_header(8'hFF);
    run_random(ITEMS_PER_PHASE);
    drain();
    write_header(8'($urandom_range(1, 254)));
    run_random(ITEMS_PER_PHASE);
    drain();
    write_header(fbr_pkg::HEADER_RESET);
    run_random(ITEMS_PER_PHASE);
    drain();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[framed_byte_receiver_two_slot_unit] OK");
    end else begin
      $display("[framed_byte_receiver_two_slot_unit] ERROR");
    end
    $finish;
  end

endmodule
